// ----- rtl/vn_pkg.sv -----
// Package for the 4-component vector normalizer.
// Holds payload structs, pipeline cell structs and sizing constants; no dependencies.
package vn_pkg;

  localparam int COMPONENT_WIDTH = 32;
  localparam int MAG_WIDTH       = COMPONENT_WIDTH + 1;
  localparam int SUM_WIDTH       = 2 * COMPONENT_WIDTH + 1;
  localparam int RAD_WIDTH       = 2 * MAG_WIDTH;
  localparam int REM_WIDTH       = MAG_WIDTH + 2;
  localparam int UNIT_FRAC       = 30;
  localparam int QUO_WIDTH       = UNIT_FRAC + 1;
  localparam int DREM_WIDTH      = MAG_WIDTH + 1;
  localparam int TOL_WIDTH       = 16;
  localparam int SQRT_CELLS      = MAG_WIDTH;
  localparam int DIV_CELLS       = QUO_WIDTH;
  localparam int ADDR_WIDTH      = 3;
  localparam logic [0:0] REG_ZERO_TOLERANCE = 1'b0;
  localparam logic [TOL_WIDTH-1:0] TOL_RESET = 16'd1;

  typedef struct packed {
    logic signed [COMPONENT_WIDTH-1:0] in_x;
    logic signed [COMPONENT_WIDTH-1:0] in_y;
    logic signed [COMPONENT_WIDTH-1:0] in_z;
    logic signed [COMPONENT_WIDTH-1:0] in_w;
  } vec_in_t;

  typedef struct packed {
    logic signed [31:0]          unit_x;
    logic signed [31:0]          unit_y;
    logic signed [31:0]          unit_z;
    logic signed [31:0]          unit_w;
    logic        [MAG_WIDTH-1:0] magnitude;
    logic                        was_zero;
  } vec_out_t;

  typedef struct packed {
    logic [3:0]                      neg;
    logic [3:0][COMPONENT_WIDTH-1:0] mag;
  } lane_t;

  typedef struct packed {
    logic [RAD_WIDTH-1:0] rad;
    logic [MAG_WIDTH-1:0] root;
    logic [REM_WIDTH-1:0] rem;
  } sqrt_t;

  typedef struct packed {
    logic [MAG_WIDTH-1:0]       len;
    logic                       zero;
    logic [3:0]                 neg;
    logic [3:0][DREM_WIDTH-1:0] rem;
    logic [3:0][QUO_WIDTH-1:0]  quo;
  } div_t;

endpackage

// ----- rtl/vn_sqrt_cell.sv -----
// One cell of the square root chain: resolves one root bit per stage.
// Uses vn_pkg.
module vn_sqrt_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          valid_in,
  input  vn_pkg::lane_t lane_in,
  input  vn_pkg::sqrt_t sq_in,
  output logic          valid,
  output vn_pkg::lane_t lane,
  output vn_pkg::sqrt_t sq
);

  logic [vn_pkg::REM_WIDTH+1:0] cur;
  logic [vn_pkg::REM_WIDTH+1:0] trial;
  vn_pkg::sqrt_t                sq_next;

  always_comb begin
    cur   = {sq_in.rem, sq_in.rad[vn_pkg::RAD_WIDTH-1 -: 2]};
    trial = {2'b00, sq_in.root, 2'b01};
    sq_next.rad = {sq_in.rad[vn_pkg::RAD_WIDTH-3:0], 2'b00};
    if (cur >= trial) begin
      sq_next.rem  = vn_pkg::REM_WIDTH'(cur - trial);
      sq_next.root = {sq_in.root[vn_pkg::MAG_WIDTH-2:0], 1'b1};
    end else begin
      sq_next.rem  = cur[vn_pkg::REM_WIDTH-1:0];
      sq_next.root = {sq_in.root[vn_pkg::MAG_WIDTH-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lane <= lane_in;
      sq   <= sq_next;
    end
  end

endmodule

// ----- rtl/vn_div_cell.sv -----
// One cell of the divide chain: one quotient bit for all four lanes.
// Uses vn_pkg.
module vn_div_cell (
  input  logic         clk,
  input  logic         rst,
  input  logic         en,
  input  logic         valid_in,
  input  vn_pkg::div_t dv_in,
  output logic         valid,
  output vn_pkg::div_t dv
);

  vn_pkg::div_t dv_next;
  logic [vn_pkg::DREM_WIDTH-1:0] r;

  always_comb begin
    dv_next = dv_in;
    for (int i = 0; i < 4; i++) begin
      if (dv_in.rem[i] >= {1'b0, dv_in.len}) begin
        r = dv_in.rem[i] - {1'b0, dv_in.len};
        dv_next.quo[i] = {dv_in.quo[i][vn_pkg::QUO_WIDTH-2:0], 1'b1};
      end else begin
        r = dv_in.rem[i];
        dv_next.quo[i] = {dv_in.quo[i][vn_pkg::QUO_WIDTH-2:0], 1'b0};
      end
      dv_next.rem[i] = {r[vn_pkg::DREM_WIDTH-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv <= dv_next;
    end
  end

endmodule

// ----- rtl/vector4_normalize_core.sv -----
// Top level of the 4-component vector normalizer: squares, sum, root chain, divide chain.
// Uses vn_pkg, vn_sqrt_cell, vn_div_cell.
// Takes one request per clock while req_stall is low and returns one result per request,
// in order, after 3 stages of squaring and summing, 33 root cells and 31 divide cells.
// The whole pipeline holds while a waiting result is stalled. zero_tolerance sits
// at byte address 0.
module vector4_normalize_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            req_valid,
  output logic                            req_stall,
  input  vn_pkg::vec_in_t                 req_data,
  output logic                            rsp_valid,
  input  logic                            rsp_stall,
  output vn_pkg::vec_out_t                rsp_data,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [vn_pkg::ADDR_WIDTH-1:0]   paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  localparam int CW = vn_pkg::COMPONENT_WIDTH;

  logic                          en;
  logic [vn_pkg::TOL_WIDTH-1:0]  zero_tolerance;

  assign pready = 1'b1;
  assign prdata = (paddr[vn_pkg::ADDR_WIDTH-1] == vn_pkg::REG_ZERO_TOLERANCE)
                ? {16'd0, zero_tolerance} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_tolerance <= vn_pkg::TOL_RESET;
    end else if (psel && penable && pwrite &&
                 paddr[vn_pkg::ADDR_WIDTH-1] == vn_pkg::REG_ZERO_TOLERANCE) begin
      zero_tolerance <= pwdata[vn_pkg::TOL_WIDTH-1:0];
    end
  end

  assign en        = !(rsp_valid && rsp_stall);
  assign req_stall = !en;

  // square and sum stages
  logic [3:0][CW-1:0] comp;
  logic [3:0][CW-1:0] mag_in;
  logic [3:0]         neg_in;
  logic               v1, v2, v3;
  vn_pkg::lane_t      l1, l2, l3;
  logic [3:0][2*CW-1:0] sq1;
  logic [vn_pkg::SUM_WIDTH-1:0] p01, p23, sum3;

  always_comb begin
    comp = {req_data.in_w, req_data.in_z, req_data.in_y, req_data.in_x};
    for (int i = 0; i < 4; i++) begin
      neg_in[i] = comp[i][CW-1];
      mag_in[i] = neg_in[i] ? (~comp[i] + 1'b1) : comp[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= req_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      l1.neg <= neg_in;
      l1.mag <= mag_in;
      for (int i = 0; i < 4; i++) begin
        sq1[i] <= mag_in[i] * mag_in[i];
      end
      l2   <= l1;
      p01  <= {1'b0, sq1[0]} + {1'b0, sq1[1]};
      p23  <= {1'b0, sq1[2]} + {1'b0, sq1[3]};
      l3   <= l2;
      sum3 <= p01 + p23;
    end
  end

  // root chain
  logic          sv [0:vn_pkg::SQRT_CELLS];
  vn_pkg::lane_t sl [0:vn_pkg::SQRT_CELLS];
  vn_pkg::sqrt_t ss [0:vn_pkg::SQRT_CELLS];

  assign sv[0]      = v3;
  assign sl[0]      = l3;
  assign ss[0].rad  = {1'b0, sum3};
  assign ss[0].root = '0;
  assign ss[0].rem  = '0;

  for (genvar g = 0; g < vn_pkg::SQRT_CELLS; g++) begin : g_sqrt
    vn_sqrt_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .valid_in (sv[g]),
      .lane_in  (sl[g]),
      .sq_in    (ss[g]),
      .valid    (sv[g+1]),
      .lane     (sl[g+1]),
      .sq       (ss[g+1])
    );
  end

  // divide chain
  logic         dvv [0:vn_pkg::DIV_CELLS];
  vn_pkg::div_t dd  [0:vn_pkg::DIV_CELLS];
  vn_pkg::lane_t lf;

  assign lf         = sl[vn_pkg::SQRT_CELLS];
  assign dvv[0]     = sv[vn_pkg::SQRT_CELLS];
  assign dd[0].len  = ss[vn_pkg::SQRT_CELLS].root;
  assign dd[0].zero = ss[vn_pkg::SQRT_CELLS].root <=
                      {{(vn_pkg::MAG_WIDTH-vn_pkg::TOL_WIDTH){1'b0}}, zero_tolerance};
  assign dd[0].neg  = lf.neg;
  assign dd[0].quo  = '0;
  for (genvar k = 0; k < 4; k++) begin : g_lane
    assign dd[0].rem[k] = {{(vn_pkg::DREM_WIDTH-CW){1'b0}}, lf.mag[k]};
  end

  for (genvar g = 0; g < vn_pkg::DIV_CELLS; g++) begin : g_div
    vn_div_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .valid_in (dvv[g]),
      .dv_in    (dd[g]),
      .valid    (dvv[g+1]),
      .dv       (dd[g+1])
    );
  end

  vn_pkg::div_t   fin;
  logic [3:0][31:0] unit;

  assign fin       = dd[vn_pkg::DIV_CELLS];
  assign rsp_valid = dvv[vn_pkg::DIV_CELLS];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (fin.zero) begin
        unit[i] = '0;
      end else if (fin.neg[i]) begin
        unit[i] = ~{1'b0, fin.quo[i]} + 1'b1;
      end else begin
        unit[i] = {1'b0, fin.quo[i]};
      end
    end
    rsp_data.unit_x    = unit[0];
    rsp_data.unit_y    = unit[1];
    rsp_data.unit_z    = unit[2];
    rsp_data.unit_w    = unit[3];
    rsp_data.magnitude = fin.len;
    rsp_data.was_zero  = fin.zero;
  end

endmodule

// ----- rtl/vn_checker.sv -----
// Port-level checks for vector4_normalize_core, bound to the top level.
// Uses vn_pkg.
module vn_checker (
  input logic             clk,
  input logic             rst,
  input logic             req_stall,
  input logic             rsp_valid,
  input logic             rsp_stall,
  input vn_pkg::vec_out_t rsp_data
);

  a_reset_idle: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid right after reset");

  a_stall_only_backpressure: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> (rsp_valid && rsp_stall))
    else $error("request stalled without a stalled result");

  a_zero_units: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_data.was_zero) |->
      (rsp_data.unit_x == 0 && rsp_data.unit_y == 0 &&
       rsp_data.unit_z == 0 && rsp_data.unit_w == 0))
    else $error("zero result with nonzero components");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
    else $error("stalled result changed");

endmodule

bind vector4_normalize_core vn_checker u_vn_checker (
  .clk       (clk),
  .rst       (rst),
  .req_stall (req_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp_data  (rsp_data)
);

// ----- tb/sv/vector4_normalize_core_tb.sv -----
// Testbench for vector4_normalize_core: directed table plus random vectors, each result
// checked in order against a fixed table entry or a behavioral normalizer with its own
// copy of zero_tolerance. Depends on vn_pkg and the RTL of vector4_normalize_core.
module vector4_normalize_core_tb;

  localparam int PIPE_LATENCY = 67;
  localparam int CYCLE_LIMIT  = 900000;
  localparam logic [vn_pkg::ADDR_WIDTH-1:0] ADDR_ZERO_TOL =
    {vn_pkg::REG_ZERO_TOLERANCE, 2'b00};

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  typedef struct {
    logic signed [31:0] x, y, z, w;
    logic               fixed_known;
    vn_pkg::vec_out_t   fixed_rsp;
  } vec_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  vn_pkg::vec_in_t req_data = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  vn_pkg::vec_out_t rsp_data;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [vn_pkg::ADDR_WIDTH-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  vn_pkg::vec_out_t expected_units[$];
  logic [15:0] tol_shadow = vn_pkg::TOL_RESET;
  int mismatch_count = 0;
  int cycle_count = 0;
  idle_mode_e idle_mode = IDLE_NONE;
  int hold_rsp_cycles = 0;
  vec_row_t vec_table[$];

  vector4_normalize_core dut (.*);

  always #5 clk = ~clk;

  function automatic logic [63:0] isqrt_wide(logic [65:0] s);
    logic [63:0] root;
    logic [63:0] cand;
    root = '0;
    for (int b = 33; b >= 0; b--) begin
      cand = root | (64'd1 << b);
      if ({66'd0, cand} * {66'd0, cand} <= {66'd0, s}) root = cand;
    end
    return root;
  endfunction

  function automatic vn_pkg::vec_out_t normalize_vec(vn_pkg::vec_in_t v, logic [15:0] tol);
    vn_pkg::vec_out_t r;
    logic [31:0] comp[4];
    logic [32:0] mag[4];
    logic        neg[4];
    logic [65:0] sumsq;
    logic [63:0] len;
    logic [95:0] q;
    comp = '{v.in_x, v.in_y, v.in_z, v.in_w};
    sumsq = '0;
    for (int i = 0; i < 4; i++) begin
      neg[i] = comp[i][31];
      mag[i] = neg[i] ? 33'(-{1'b1, comp[i]}) : {1'b0, comp[i]};
      sumsq += 66'(mag[i]) * 66'(mag[i]);
    end
    len = isqrt_wide(sumsq);
    r = '0;
    r.magnitude = (len > 64'h1FFFFFFFF) ? '1 : len[32:0];
    if (len <= {48'd0, tol}) begin
      r.was_zero = 1'b1;
      return r;
    end
    for (int i = 0; i < 4; i++) begin
      q = ({63'd0, mag[i]} << 30) / {32'd0, len};
      comp[i] = neg[i] ? -q[31:0] : q[31:0];
    end
    r.unit_x = comp[0]; r.unit_y = comp[1]; r.unit_z = comp[2]; r.unit_w = comp[3];
    return r;
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // receiver stall pattern
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else if (hold_rsp_cycles > 0) begin
      rsp_stall <= 1'b1;
      hold_rsp_cycles <= hold_rsp_cycles - 1;
    end else if (idle_mode == IDLE_RECV) begin
      rsp_stall <= ($urandom_range(99) < 70);
    end else if (idle_mode == IDLE_BOTH) begin
      rsp_stall <= ($urandom_range(99) < 17);
    end else begin
      rsp_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    vn_pkg::vec_out_t exp_r;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_units.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result %h", rsp_data);
      end else begin
        exp_r = expected_units.pop_front();
        if (rsp_data !== exp_r) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: exp x=%h y=%h z=%h w=%h mag=%h zero=%b",
                     exp_r.unit_x, exp_r.unit_y, exp_r.unit_z, exp_r.unit_w,
                     exp_r.magnitude, exp_r.was_zero,
                     " / got x=%h y=%h z=%h w=%h mag=%h zero=%b",
                     rsp_data.unit_x, rsp_data.unit_y, rsp_data.unit_z,
                     rsp_data.unit_w, rsp_data.magnitude, rsp_data.was_zero);
        end
      end
    end
  end

  task automatic write_tol(logic [15:0] val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= ADDR_ZERO_TOL; pwdata <= {16'd0, val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    tol_shadow = val;
  endtask

  task automatic drain_and_settle();
    while (expected_units.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 5) @(posedge clk);
  endtask

  task automatic send_vec(vn_pkg::vec_in_t v, logic fixed_known,
                          vn_pkg::vec_out_t fixed_rsp);
    if (idle_mode == IDLE_SEND || idle_mode == IDLE_BOTH) begin
      while ($urandom_range(99) < ((idle_mode == IDLE_SEND) ? 70 : 17)) begin
        req_valid <= 1'b0;
        @(posedge clk);
      end
    end
    req_valid <= 1'b1;
    req_data <= v;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    expected_units.push_back(fixed_known ? fixed_rsp : normalize_vec(v, tol_shadow));
  endtask

  function automatic logic [31:0] rand_comp();
    case ($urandom_range(5))
      0: return $urandom_range(3) == 0 ? 32'h80000000 : 32'h7FFFFFFF;
      1: return 32'($signed($urandom_range(8)) - 4);
      2: return 32'($signed($urandom_range(400000)) - 200000);
      default: return $urandom;
    endcase
  endfunction

  task automatic random_phase(int n);
    vn_pkg::vec_in_t v;
    for (int i = 0; i < n; i++) begin
      v.in_x = rand_comp(); v.in_y = rand_comp(); v.in_z = rand_comp(); v.in_w = rand_comp();
      send_vec(v, 1'b0, '0);
    end
  endtask

  initial begin
    vn_pkg::vec_in_t v;
    vn_pkg::vec_out_t zero_rsp, one_rsp;
    zero_rsp = '0; zero_rsp.was_zero = 1'b1;
    one_rsp = '0; one_rsp.unit_x = 32'sh40000000; one_rsp.magnitude = 33'h10000;
    vec_table = '{
      '{0, 0, 0, 0, 1'b1, zero_rsp},
      '{1, 0, 0, 0, 1'b1, '{0, 0, 0, 0, 33'd1, 1'b1}},
      '{32'sh10000, 0, 0, 0, 1'b1, one_rsp},
      '{2, 0, 0, 0, 1'b0, '0},
      '{0, -2, 0, 0, 1'b0, '0},
      '{32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 1'b0, '0},
      '{32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000, 1'b0, '0},
      '{32'sh80000000, 0, 0, 0, 1'b0, '0},
      '{0, 0, 0, 32'sh80000000, 1'b0, '0},
      '{-1, -1, -1, -1, 1'b0, '0},
      '{3, 4, 0, 0, 1'b0, '0},
      '{32'sh7FFFFFFF, 32'sh80000000, 1, -1, 1'b0, '0},
      '{32'sh55555555, 32'shAAAAAAAA, 32'sh12345678, 32'shEDCBA987, 1'b0, '0},
      '{0, 0, 32'sh10000, -32'sh10000, 1'b0, '0}
    };
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (vec_table[i]) begin
      v = '{vec_table[i].x, vec_table[i].y, vec_table[i].z, vec_table[i].w};
      send_vec(v, vec_table[i].fixed_known, vec_table[i].fixed_rsp);
    end
    req_valid <= 1'b0;
    drain_and_settle();
    write_tol(16'd0);
    for (int i = 0; i < 4; i++) begin
      send_vec('{32'(i), 0, 0, 0}, 1'b0, '0);
      send_vec('{32'(-i), 0, 0, 0}, 1'b0, '0);
    end
    req_valid <= 1'b0;
    drain_and_settle();
    write_tol(16'hFFFF);
    send_vec('{32'sh10000, -1, 0, 0}, 1'b0, '0);
    send_vec('{32'shFFFF, 0, 0, 0}, 1'b0, '0);
    send_vec('{0, 32'sh10001, 0, 0}, 1'b0, '0);
    random_phase(40);
    req_valid <= 1'b0;
    drain_and_settle();
    write_tol(16'd1);
    idle_mode = IDLE_NONE; random_phase(250);
    // long receiver hold so the pipeline fills
    hold_rsp_cycles = 300;
    idle_mode = IDLE_NONE; random_phase(150);
    req_valid <= 1'b0;
    drain_and_settle();
    write_tol(16'd200);
    idle_mode = IDLE_SEND; random_phase(200);
    idle_mode = IDLE_RECV; random_phase(200);
    idle_mode = IDLE_BOTH; random_phase(200);
    req_valid <= 1'b0;
    idle_mode = IDLE_NONE;
    drain_and_settle();
    if (mismatch_count == 0 && expected_units.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
rtl/vn_pkg.sv
rtl/vn_sqrt_cell.sv
rtl/vn_div_cell.sv
rtl/vector4_normalize_core.sv
rtl/vn_checker.sv
tb/sv/vector4_normalize_core_tb.sv
